// ===== hw/rtl/fdd_pkg.sv =====
package fdd_pkg;

  // Ring geometry
  localparam int unsigned MAX_DELAY = 65536;
  localparam int unsigned CHANNELS  = 2;
  localparam int unsigned PTR_W     = $clog2(MAX_DELAY);
  localparam int unsigned CH_SEL_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MEM_DEPTH = CHANNELS * MAX_DELAY;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  // Fixed point
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned GAIN_W    = 15;
  localparam int unsigned MIX_W     = 16;
  localparam int unsigned FRAC_W    = 15;
  localparam int unsigned ONE_Q15   = 32768;
  localparam int unsigned HALF_Q15  = 16384;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY    = 2'd0,
    CFG_FEEDBACK = 2'd1,
    CFG_MIX      = 2'd2
  } fdd_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_WRITE
  } fdd_state_e;

  typedef struct packed {
    logic               channel;
    logic signed [15:0] dry_sample;
  } fdd_in_t;

  typedef struct packed {
    logic               out_channel;
    logic signed [15:0] mixed_sample;
  } fdd_out_t;

  // Sequencer to datapath
  typedef struct packed {
    logic mul_en;   // capture products this cycle
    logic wet_hit;  // read entry holds a written value
  } fdd_mac_ctrl_t;

endpackage

// ===== hw/rtl/fdd_echo_mem.sv =====
module fdd_echo_mem (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic                                 we_i,
  input  logic [fdd_pkg::MEM_AW-1:0]           addr_i,
  input  logic signed [fdd_pkg::SAMPLE_W-1:0]  wdata_i,
  output logic signed [fdd_pkg::SAMPLE_W-1:0]  rdata_o
);
  import fdd_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fdd_mac.sv =====
module fdd_mac (
  input  logic                                 clk_i,
  input  fdd_pkg::fdd_mac_ctrl_t               ctrl_i,
  input  logic signed [fdd_pkg::SAMPLE_W-1:0]  dry_i,
  input  logic signed [fdd_pkg::SAMPLE_W-1:0]  wet_raw_i,
  input  logic [fdd_pkg::GAIN_W-1:0]           feedback_gain_i,
  input  logic [fdd_pkg::MIX_W-1:0]            wet_mix_i,
  output logic signed [fdd_pkg::SAMPLE_W-1:0]  ring_value_o,
  output logic signed [fdd_pkg::SAMPLE_W-1:0]  mixed_o
);
  import fdd_pkg::*;

  localparam int unsigned M_W   = MIX_W + 1;
  localparam int unsigned P_W   = M_W + SAMPLE_W + 1;
  localparam int unsigned SUM_W = P_W + 3;

  logic [M_W-1:0]             mix_clamped;
  logic [M_W-1:0]             dry_weight;
  logic signed [SAMPLE_W-1:0] wet;

  logic signed [SAMPLE_W-1:0] dry_q;
  logic signed [P_W-1:0]      p_fb_q, p_dry_q, p_wet_q;

  logic signed [SUM_W-1:0]    fb_sum, mix_sum, fb_shr, mix_shr;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(32767)) begin
      return 16'sh7FFF;
    end else if (v < -SUM_W'(32768)) begin
      return 16'sh8000;
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

  always_comb begin
    mix_clamped = (M_W'(wet_mix_i) > M_W'(ONE_Q15)) ? M_W'(ONE_Q15) : M_W'(wet_mix_i);
    dry_weight  = M_W'(ONE_Q15) - mix_clamped;
    // never-written entries read as zero
    wet         = ctrl_i.wet_hit ? wet_raw_i : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      dry_q   <= dry_i;
      p_fb_q  <= P_W'($signed({1'b0, feedback_gain_i}) * wet);
      p_dry_q <= P_W'($signed({1'b0, dry_weight}) * dry_i);
      p_wet_q <= P_W'($signed({1'b0, mix_clamped}) * wet);
    end
  end

  always_comb begin
    fb_sum  = (SUM_W'(dry_q) <<< FRAC_W) + SUM_W'(p_fb_q) + SUM_W'(HALF_Q15);
    mix_sum = SUM_W'(p_dry_q) + SUM_W'(p_wet_q) + SUM_W'(HALF_Q15);
    fb_shr  = fb_sum >>> FRAC_W;
    mix_shr = mix_sum >>> FRAC_W;
    ring_value_o = sat16(fb_shr);
    mixed_o      = sat16(mix_shr);
  end

endmodule

// ===== hw/rtl/feedback_delay_dry_wet_unit.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  in_data_i   (channel, dry_sample)
// out       output     out_valid_o/out_ready_i out_data_o (out_channel, mixed_sample)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction steps through accept, ring read, multiply and write back, in order.
// The single-port echo memory (read then write of the same ring) keeps these steps apart.
// Reset clears control state and positions and sets config defaults; the ring needs
// no clearing pass, a per-channel wrap flag marks unwritten entries, read as zero.
// A held result stalls the write-back step; the next item waits until it drains.
module feedback_delay_dry_wet_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fdd_pkg::fdd_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fdd_pkg::fdd_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fdd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fdd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import fdd_pkg::*;

  fdd_state_e state_q, state_d;

  logic [DELAY_W-1:0] delay_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [MIX_W-1:0]   mix_q;

  fdd_in_t              item_q;
  logic [PTR_W-1:0]     wp_q [CHANNELS];
  logic [CHANNELS-1:0]  wrapped_q;
  logic                 hit_q, hit_d;

  fdd_out_t out_q;
  logic     out_valid_q;

  logic [CH_SEL_W-1:0] ch;
  logic [PTR_W-1:0]    wp, rp, wp_next;
  logic [31:0]         d32, rp32;

  logic                       mem_en, mem_we;
  logic [MEM_AW-1:0]          mem_addr;
  logic signed [SAMPLE_W-1:0] mem_rdata, ring_value, mixed;
  fdd_mac_ctrl_t              mac_ctrl;

  logic in_fire, write_go;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_W'(16800);
      gain_q  <= GAIN_W'(13107);
      mix_q   <= MIX_W'(9830);
    end else if (cfg_valid_i) begin
      case (fdd_cfg_idx_e'(cfg_index_i))
        CFG_DELAY:    delay_q <= cfg_data_i[DELAY_W-1:0];
        CFG_FEEDBACK: gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_MIX:      mix_q   <= cfg_data_i[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring addressing
  always_comb begin
    ch  = (CHANNELS > 1) ? CH_SEL_W'(item_q.channel) : '0;
    wp  = wp_q[ch];
    d32 = 32'(delay_q);
    if (d32 < 32'd1) begin
      d32 = 32'd1;
    end
    if (d32 > 32'(MAX_DELAY - 1)) begin
      d32 = 32'(MAX_DELAY - 1);
    end
    if (32'(wp) >= d32) begin
      rp32 = 32'(wp) - d32;
    end else begin
      rp32 = 32'(wp) + 32'(MAX_DELAY) - d32;
    end
    rp      = rp32[PTR_W-1:0];
    wp_next = (32'(wp) == 32'(MAX_DELAY - 1)) ? '0 : wp + PTR_W'(1);
  end

  assign in_fire  = in_valid_i && in_ready_o;
  assign write_go = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    mem_en       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = MEM_AW'(MEM_AW'(ch) * MEM_AW'(MAX_DELAY)) + MEM_AW'(rp);
    hit_d        = hit_q;
    mac_ctrl.mul_en  = 1'b0;
    mac_ctrl.wet_hit = hit_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mem_en  = 1'b1;
        hit_d   = wrapped_q[ch] || (rp < wp);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        mem_addr = MEM_AW'(MEM_AW'(ch) * MEM_AW'(MAX_DELAY)) + MEM_AW'(wp);
        if (write_go) begin
          mem_en  = 1'b1;
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hit_q       <= 1'b0;
      wrapped_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
      if (write_go) begin
        wp_q[ch] <= wp_next;
        if (32'(wp) == 32'(MAX_DELAY - 1)) begin
          wrapped_q[ch] <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (write_go) begin
      out_q.out_channel  <= item_q.channel;
      out_q.mixed_sample <= mixed;
    end
  end

  fdd_echo_mem u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (ring_value),
    .rdata_o (mem_rdata)
  );

  fdd_mac u_mac (
    .clk_i           (clk_i),
    .ctrl_i          (mac_ctrl),
    .dry_i           (item_q.dry_sample),
    .wet_raw_i       (mem_rdata),
    .feedback_gain_i (gain_q),
    .wet_mix_i       (mix_q),
    .ring_value_o    (ring_value),
    .mixed_o         (mixed)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
